// ----- rtl/core/space_vector_modulation_defines.svh -----
// Assertion macros for the space vector modulation block.
// Both macros assume a clock named clk and an active-low reset named rst_n.
`ifndef SPACE_VECTOR_MODULATION_DEFINES_SVH
`define SPACE_VECTOR_MODULATION_DEFINES_SVH
`ifndef SYNTH
`define SVM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svm assertion failed");
`define SVM_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svm assertion failed");
`else
`define SVM_ASSERT_IMP(label, ante, cons)
`define SVM_ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- rtl/core/svm_pkg.sv -----
package svm_pkg;

  localparam int SAMPLE_W = 16;
  localparam int FRAC_W   = SAMPLE_W - 1;
  localparam int GUARD_W  = 16;
  // x, y, z and the sector times
  localparam int PROD_W   = SAMPLE_W + GUARD_W + 2;
  // t1 + t2
  localparam int SUM_W    = PROD_W + 1;
  // twice a duty
  localparam int DSUM_W   = PROD_W + 2;
  localparam int RND_W    = DSUM_W - GUARD_W - 1;

  localparam logic signed [17:0] ROOT3_HALF = 18'sd56756;

  localparam logic [SAMPLE_W-1:0] DUTY_FULL = SAMPLE_W'(1) << FRAC_W;
  localparam logic [SAMPLE_W-1:0] HALF_DUTY = SAMPLE_W'(1) << (FRAC_W - 1);

  // 1.0 and 0.5, doubled, in units of 2^-(F+16)
  localparam logic signed [DSUM_W-1:0] ONE_TWICE  = DSUM_W'(1) <<< (FRAC_W + GUARD_W + 1);
  localparam logic signed [DSUM_W-1:0] HALF_TWICE = DSUM_W'(1) <<< (FRAC_W + GUARD_W);

  typedef enum logic [2:0] {
    SEC_NONE = 3'd0,
    SEC_1    = 3'd1,
    SEC_2    = 3'd2,
    SEC_3    = 3'd3,
    SEC_4    = 3'd4,
    SEC_5    = 3'd5,
    SEC_6    = 3'd6
  } svm_sector_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] alpha;
    logic signed [SAMPLE_W-1:0] beta;
  } svm_in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] duty_a;
    logic [SAMPLE_W-1:0] duty_b;
    logic [SAMPLE_W-1:0] duty_c;
    logic [2:0]          sector;
  } svm_out_t;

  // handed from the projection half to the duty half
  typedef struct packed {
    logic signed [SUM_W-1:0]  sum;
    logic signed [PROD_W-1:0] tm;
    svm_sector_t              sector;
  } svm_mid_t;

endpackage

// ----- rtl/core/svm_proj.sv -----
`include "space_vector_modulation_defines.svh"

module svm_proj
  import svm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  svm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output svm_mid_t out_data
);

  // sign code: x>0 adds 1, y>0 adds 2, z>0 adds 4
  localparam logic [2:0] CODE_S1 = 3'd5;
  localparam logic [2:0] CODE_S2 = 3'd1;
  localparam logic [2:0] CODE_S3 = 3'd3;
  localparam logic [2:0] CODE_S4 = 3'd2;
  localparam logic [2:0] CODE_S5 = 3'd6;
  localparam logic [2:0] CODE_S6 = 3'd4;

  // stage 1: alpha * sqrt3/2
  logic                       v1_r, rdy1;
  logic signed [PROD_W-1:0]   ka_r, ka_nxt;
  logic signed [SAMPLE_W-1:0] b_r;

  // stage 2: x, y, z
  logic                     v2_r, rdy2;
  logic signed [PROD_W-1:0] x_r, y_r, z_r, x_nxt, y_nxt, z_nxt, hb;

  // stage 3: sector, t1 + t2, middle time
  logic                     v3_r, rdy3;
  svm_mid_t                 mid_r, mid_nxt;
  logic signed [PROD_W-1:0] t1, t2;
  logic [2:0]               code;

  assign rdy3 = !v3_r || out_ready;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign ka_nxt = in_data.alpha * ROOT3_HALF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_valid;
    end
    if (rdy1 && in_valid) begin
      ka_r <= ka_nxt;
      b_r  <= in_data.beta;
    end
  end

  always_comb begin
    x_nxt = PROD_W'(b_r) <<< GUARD_W;
    hb    = PROD_W'(b_r) <<< (GUARD_W - 1);
    y_nxt = -hb - ka_r;
    z_nxt = ka_r - hb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
    if (rdy2 && v1_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  always_comb begin
    code[0] = !x_r[PROD_W-1] && (x_r != '0);
    code[1] = !y_r[PROD_W-1] && (y_r != '0);
    code[2] = !z_r[PROD_W-1] && (z_r != '0);
    t1 = '0;
    t2 = '0;
    mid_nxt.sector = SEC_NONE;
    mid_nxt.tm     = '0;
    case (code)
      CODE_S1: begin
        mid_nxt.sector = SEC_1; t1 = z_r;  t2 = x_r;  mid_nxt.tm = t2;
      end
      CODE_S2: begin
        mid_nxt.sector = SEC_2; t1 = -y_r; t2 = -z_r; mid_nxt.tm = t1;
      end
      CODE_S3: begin
        mid_nxt.sector = SEC_3; t1 = x_r;  t2 = y_r;  mid_nxt.tm = t2;
      end
      CODE_S4: begin
        mid_nxt.sector = SEC_4; t1 = -z_r; t2 = -x_r; mid_nxt.tm = t1;
      end
      CODE_S5: begin
        mid_nxt.sector = SEC_5; t1 = y_r;  t2 = z_r;  mid_nxt.tm = t2;
      end
      CODE_S6: begin
        mid_nxt.sector = SEC_6; t1 = -x_r; t2 = -y_r; mid_nxt.tm = t1;
      end
      default: begin
        mid_nxt.sector = SEC_NONE;
      end
    endcase
    mid_nxt.sum = SUM_W'(t1) + SUM_W'(t2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
    if (rdy3 && v2_r) begin
      mid_r <= mid_nxt;
    end
  end

  assign out_valid = v3_r;
  assign out_data  = mid_r;

  `SVM_ASSERT_NXT(a_proj_advance, v1_r && rdy2, v2_r)
  `SVM_ASSERT_IMP(a_proj_times_pos, v3_r, !mid_r.sum[SUM_W-1] && !mid_r.tm[PROD_W-1])
  `SVM_ASSERT_IMP(a_proj_none_zero, v3_r && (mid_r.sector == SEC_NONE), mid_r.sum == '0)

endmodule

// ----- rtl/core/svm_duty.sv -----
module svm_duty
  import svm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  svm_mid_t in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output svm_out_t out_data
);

  // twice a duty in units of 2^-(F+16) to Q1.F, round half up, clamp
  function automatic logic [SAMPLE_W-1:0] finish_duty(input logic signed [DSUM_W-1:0] twice);
    logic [DSUM_W-1:0] rnd;
    logic [RND_W-1:0]  r;
    rnd = twice + (DSUM_W'(1) <<< GUARD_W);
    r   = rnd[DSUM_W-1:GUARD_W+1];
    if (twice[DSUM_W-1] || (twice == '0)) begin
      finish_duty = '0;
    end else if (r > RND_W'(DUTY_FULL)) begin
      finish_duty = DUTY_FULL;
    end else begin
      finish_duty = r[SAMPLE_W-1:0];
    end
  endfunction

  // stage 4: twice each duty
  logic                     v4_r, rdy4;
  logic signed [DSUM_W-1:0] da_r, db_r, dc_r, da_nxt, db_nxt, dc_nxt;
  logic signed [DSUM_W-1:0] d_lo, d_mid, d_hi;
  svm_sector_t              sec4_r;

  // stage 5: output register
  logic     v5_r, rdy5;
  svm_out_t out_r, out_nxt;

  assign rdy5 = !v5_r || out_ready;
  assign rdy4 = !v4_r || rdy5;
  assign in_ready = rdy4;

  always_comb begin
    d_lo  = ONE_TWICE - DSUM_W'(in_data.sum);
    d_hi  = ONE_TWICE + DSUM_W'(in_data.sum);
    d_mid = d_lo + (DSUM_W'(in_data.tm) <<< 1);
    case (in_data.sector)
      SEC_1: begin da_nxt = d_hi;  db_nxt = d_mid; dc_nxt = d_lo;  end
      SEC_2: begin da_nxt = d_mid; db_nxt = d_hi;  dc_nxt = d_lo;  end
      SEC_3: begin da_nxt = d_lo;  db_nxt = d_hi;  dc_nxt = d_mid; end
      SEC_4: begin da_nxt = d_lo;  db_nxt = d_mid; dc_nxt = d_hi;  end
      SEC_5: begin da_nxt = d_mid; db_nxt = d_lo;  dc_nxt = d_hi;  end
      SEC_6: begin da_nxt = d_hi;  db_nxt = d_lo;  dc_nxt = d_mid; end
      default: begin
        da_nxt = HALF_TWICE; db_nxt = HALF_TWICE; dc_nxt = HALF_TWICE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
    end else if (rdy4) begin
      v4_r <= in_valid;
    end
    if (rdy4 && in_valid) begin
      da_r   <= da_nxt;
      db_r   <= db_nxt;
      dc_r   <= dc_nxt;
      sec4_r <= in_data.sector;
    end
  end

  always_comb begin
    out_nxt.duty_a = finish_duty(da_r);
    out_nxt.duty_b = finish_duty(db_r);
    out_nxt.duty_c = finish_duty(dc_r);
    out_nxt.sector = 3'(sec4_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= v4_r;
    end
    if (rdy5 && v4_r) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = v5_r;
  assign out_data  = out_r;

endmodule

// ----- rtl/core/space_vector_modulation.sv -----
// Space vector PWM duty calculation, five register stages.
// Path: an input transfer is registered in stages 1 to 5 in turn, and stage 5 drives
// out_valid; while out_ready is low the result waits there.
// Throughput: one vector per cycle; each stage holds its item until the next stage frees.
// Reset: synchronous on rst_n low, clears every stage valid bit; data registers keep
// whatever they hold and are ignored until refilled.
`include "space_vector_modulation_defines.svh"

module space_vector_modulation
  import svm_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  svm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output svm_out_t out_data
);

  // Front half: alpha*sqrt3/2 (the only multiplier), then x/y/z, then
  // sector decode from the signs and selection of the two sector times.
  // It hands on t1+t2, the time added for the middle phase, and the sector.
  logic     mid_valid;
  logic     mid_ready;
  svm_mid_t mid_data;

  svm_proj u_proj (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (mid_valid),
    .out_ready (mid_ready),
    .out_data  (mid_data)
  );

  // Back half: the lowest phase is 1-(t1+t2), the highest 1+(t1+t2), the
  // middle one adds twice the middle time to the lowest. All are doubled
  // values, so the rounding step divides by 2^17. Permutation by sector,
  // then round half up and clamp to 0..1.0 into the output register.
  svm_duty u_duty (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mid_valid),
    .in_ready  (mid_ready),
    .in_data   (mid_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Zero vector: all phases at one half.
  `SVM_ASSERT_IMP(a_none_half,
                  out_valid && (out_data.sector == 3'(SEC_NONE)),
                  (out_data.duty_a == HALF_DUTY) && (out_data.duty_b == HALF_DUTY) &&
                  (out_data.duty_c == HALF_DUTY))
  // Saturation never exceeds full scale.
  `SVM_ASSERT_IMP(a_duty_clamp, out_valid,
                  (out_data.duty_a <= DUTY_FULL) && (out_data.duty_b <= DUTY_FULL) &&
                  (out_data.duty_c <= DUTY_FULL))

endmodule

// ----- sim/space_vector_modulation_tb.sv -----
module space_vector_modulation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import svm_pkg::*;

  // Sign pattern {Z>0, Y>0, X>0} for each of the six sectors
  localparam logic [2:0] SGN_S1 = 3'b101;
  localparam logic [2:0] SGN_S2 = 3'b001;
  localparam logic [2:0] SGN_S3 = 3'b011;
  localparam logic [2:0] SGN_S4 = 3'b010;
  localparam logic [2:0] SGN_S5 = 3'b110;
  localparam logic [2:0] SGN_S6 = 3'b100;

  // Phase indices into the duty array
  localparam int PH_A = 0;
  localparam int PH_B = 1;
  localparam int PH_C = 2;

  // Receiver hold-off used to back the pipeline up into the input
  localparam int LONG_HOLD = 400;
  // Cycles allowed after the last result for stray transfers to show
  localparam int TAIL_CYCLES = 20;

  logic     clk;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  svm_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  svm_out_t out_data;

  // Vectors waiting to be offered, and predicted duties awaiting the output
  svm_in_t  vector_q [$];
  svm_out_t duty_q [$];

  int mismatches = 0;
  int src_gap    = 0;
  int snk_stall  = 0;
  int hold_left  = 0;
  int hold_req   = 0;
  int hold_seen  = 0;
  bit src_idle   = 1'b1;
  bit snk_idle   = 1'b1;

  space_vector_modulation DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Twice a duty, in units of 2^-(F+16), rounded half up to Q1.F and clamped to 0..1.0
  function automatic logic [SAMPLE_W-1:0] duty_round(longint twice);
    longint r;
    if (twice <= 0) return '0;
    r = (twice + (longint'(1) << GUARD_W)) >>> (GUARD_W + 1);
    if (r > longint'(DUTY_FULL)) r = longint'(DUTY_FULL);
    return SAMPLE_W'(r);
  endfunction

  // Duty triple and sector for one (alpha, beta) vector
  function automatic svm_out_t svm_duties(svm_in_t v);
    longint      a, b, x, y, z, hb, ka, t1, t2;
    longint      d [3];
    int          lo, mid, hi;
    logic [2:0]  signs;
    svm_sector_t sec;
    svm_out_t    r;
    a  = longint'($signed(v.alpha));
    b  = longint'($signed(v.beta));
    x  = b * (longint'(1) << GUARD_W);
    hb = b * (longint'(1) << (GUARD_W - 1));
    ka = a * longint'(ROOT3_HALF);
    y  = -hb - ka;
    z  = -hb + ka;
    signs = {z > 0, y > 0, x > 0};
    case (signs)
      SGN_S1: begin sec = SEC_1; t1 = z;  t2 = x;  lo = PH_C; mid = PH_B; hi = PH_A; end
      SGN_S2: begin sec = SEC_2; t1 = -y; t2 = -z; lo = PH_C; mid = PH_A; hi = PH_B; end
      SGN_S3: begin sec = SEC_3; t1 = x;  t2 = y;  lo = PH_A; mid = PH_C; hi = PH_B; end
      SGN_S4: begin sec = SEC_4; t1 = -z; t2 = -x; lo = PH_A; mid = PH_B; hi = PH_C; end
      SGN_S5: begin sec = SEC_5; t1 = y;  t2 = z;  lo = PH_B; mid = PH_A; hi = PH_C; end
      SGN_S6: begin sec = SEC_6; t1 = -x; t2 = -y; lo = PH_B; mid = PH_C; hi = PH_A; end
      default: begin
        // zero vector only: no sector, all phases at one half
        r = '{duty_a: HALF_DUTY, duty_b: HALF_DUTY, duty_c: HALF_DUTY, sector: SEC_NONE};
        return r;
      end
    endcase
    d[lo] = (longint'(1) << (FRAC_W + GUARD_W + 1)) - t1 - t2;
    // even sectors add T1 first, odd sectors T2 first
    if (sec == SEC_2 || sec == SEC_4 || sec == SEC_6) begin
      d[mid] = d[lo] + 2 * t1;
      d[hi]  = d[mid] + 2 * t2;
    end else begin
      d[mid] = d[lo] + 2 * t2;
      d[hi]  = d[mid] + 2 * t1;
    end
    r.duty_a = duty_round(d[PH_A]);
    r.duty_b = duty_round(d[PH_B]);
    r.duty_c = duty_round(d[PH_C]);
    r.sector = sec;
    return r;
  endfunction

  // Driver: offers the head of vector_q, holds it until the transfer, then, while src_idle
  // is set, waits a drawn number of cycles before offering the next one.
  always @(posedge clk) begin : drive
    bit free;
    if (!rst_n) begin
      in_valid <= 1'b0;
      src_gap  <= 0;
    end else begin
      free = !in_valid || in_ready;
      if (in_valid && in_ready) begin
        duty_q.push_back(svm_duties(in_data));
      end
      if (free) begin
        if (src_gap > 0) begin
          src_gap  <= src_gap - 1;
          in_valid <= 1'b0;
        end else if (vector_q.size() != 0) begin
          in_data  <= vector_q.pop_front();
          in_valid <= 1'b1;
          src_gap  <= src_idle ? int'($urandom_range(0, 5)) : 0;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every output transfer against the oldest prediction and
  // throttles out_ready, including one long hold-off on request.
  always @(posedge clk) begin : monitor
    svm_out_t exp_d;
    bit       rdy;
    if (!rst_n) begin
      out_ready <= 1'b0;
      snk_stall = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (duty_q.size() == 0) begin
          $display("%0t unexpected transfer: expected none, actual a=%0d b=%0d c=%0d sector=%0d",
                   $time, out_data.duty_a, out_data.duty_b, out_data.duty_c, out_data.sector);
          mismatches++;
        end else begin
          exp_d = duty_q.pop_front();
          if (out_data.duty_a !== exp_d.duty_a) begin
            $display("%0t duty_a: expected %0d actual %0d", $time, exp_d.duty_a, out_data.duty_a);
            mismatches++;
          end
          if (out_data.duty_b !== exp_d.duty_b) begin
            $display("%0t duty_b: expected %0d actual %0d", $time, exp_d.duty_b, out_data.duty_b);
            mismatches++;
          end
          if (out_data.duty_c !== exp_d.duty_c) begin
            $display("%0t duty_c: expected %0d actual %0d", $time, exp_d.duty_c, out_data.duty_c);
            mismatches++;
          end
          if (out_data.sector !== exp_d.sector) begin
            $display("%0t sector: expected %0d actual %0d", $time, exp_d.sector, out_data.sector);
            mismatches++;
          end
        end
        snk_stall = snk_idle ? int'($urandom_range(0, 5)) : 0;
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        rdy = 1'b0;
      end else if (snk_stall > 0) begin
        snk_stall = snk_stall - 1;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
      end
      out_ready <= rdy;
    end
  end

  task automatic push_vec(int a, int b);
    vector_q.push_back('{alpha: SAMPLE_W'(a), beta: SAMPLE_W'(b)});
  endtask

  // Random vectors: the largest share full range (often overmodulated), some within +-28000
  // on each axis, some near zero, and some with alpha on a rail or beta at -1.0 or zero.
  task automatic queue_random(int n);
    svm_in_t v;
    int      k;
    repeat (n) begin
      k = $urandom_range(0, 9);
      if (k < 4) begin
        v = svm_in_t'($urandom);
      end else if (k < 7) begin
        v.alpha = SAMPLE_W'(int'($urandom_range(0, 56000)) - 28000);
        v.beta  = SAMPLE_W'(int'($urandom_range(0, 56000)) - 28000);
      end else if (k < 8) begin
        v.alpha = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
        v.beta  = SAMPLE_W'(int'($urandom_range(0, 16)) - 8);
      end else begin
        v = svm_in_t'($urandom);
        if ($urandom_range(0, 1)) begin
          v.alpha = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
        end else begin
          v.beta = $urandom_range(0, 1) ? 16'h8000 : 16'h0000;
        end
      end
      vector_q.push_back(v);
    end
  endtask

  // Sender pause: nothing more is offered until every prediction has been met
  task automatic drain();
    while (vector_q.size() != 0 || in_valid || duty_q.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero vector (no sector), the rails, the smallest steps,
    // one vector in the middle of each sector, and overmodulated corners.
    push_vec(0, 0);
    push_vec(1, 0);
    push_vec(-1, 0);
    push_vec(0, 1);
    push_vec(0, -1);
    push_vec(1, 1);
    push_vec(-1, -1);
    push_vec(16000, 8000);
    push_vec(0, 16000);
    push_vec(-16000, 8000);
    push_vec(-16000, -8000);
    push_vec(0, -16000);
    push_vec(16000, -8000);
    push_vec(32767, 0);
    push_vec(-32768, 0);
    push_vec(0, 32767);
    push_vec(0, -32768);
    push_vec(32767, 32767);
    push_vec(-32768, -32768);
    push_vec(-32768, 32767);
    push_vec(32767, -32768);
    push_vec(0, 0);
    drain();

    // Back-pressure: receiver holds off while the sender streams back to back
    src_idle = 1'b0;
    hold_req++;
    queue_random(300);
    drain();

    // Both sides idling at random
    src_idle = 1'b1;
    snk_idle = 1'b1;
    queue_random(800);
    drain();

    // Full rate, no idling either side
    src_idle = 1'b0;
    snk_idle = 1'b0;
    queue_random(400);
    drain();

    // Mixed: only one side idling at a time
    src_idle = 1'b1;
    queue_random(200);
    drain();
    src_idle = 1'b0;
    snk_idle = 1'b1;
    queue_random(250);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("space_vector_modulation: match");
    end else begin
      $display("space_vector_modulation: mismatch");
    end
    $finish;
  end

  // Watchdog, well beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("space_vector_modulation: mismatch");
    $finish;
  end

endmodule
